>>> hw/rtl/rpn_pkg.sv
`default_nettype none
package rpn_pkg;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int DATA_W          = 32;
    localparam int OP_W            = 3;
    localparam int ST_W            = 3;
    localparam int DEPTH_W         = 8;
    localparam int DIV_CNT_W       = $clog2(DATA_W);

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_POP  = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd5;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd2;
    localparam logic [ST_W-1:0] ST_FEW     = 3'd3;
    localparam logic [ST_W-1:0] ST_DIVZERO = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_RD_T,
        S_RD_N,
        S_EXEC,
        S_DIV,
        S_DIV_FIN,
        S_WB,
        S_RESP
    } t_state;

    typedef struct packed {
        logic            latch_in;
        logic            set_status;
        logic [ST_W-1:0] status;
        logic            push;
        logic            rd_next;
        logic            latch_t;
        logic            latch_n;
        logic            pop;
        logic            alu;
        logic            div_start;
        logic            div_step;
        logic            div_fin;
        logic            wb;
        logic            load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            full;
        logic            empty;
        logic            few;
        logic            n_zero;
        logic            div_last;
        logic            out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

>>> hw/rtl/rpn_ram.sv
`default_nettype none
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hw/rtl/rpn_ctrl.sv
`default_nettype none
module rpn_ctrl
    import rpn_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   is_arith;

    assign is_arith = i_sts.opcode inside {[OP_ADD:OP_DIV]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_sts.opcode)
                    OP_PUSH: n_state = S_RESP;
                    OP_POP:  n_state = i_sts.empty ? S_RESP : S_RD_T;
                    default: begin
                        if (is_arith && !i_sts.few) begin
                            n_state = S_RD_T;
                        end else begin
                            n_state = S_RESP;
                        end
                    end
                endcase
            end
            S_RD_T: n_state = (i_sts.opcode == OP_POP) ? S_RESP : S_RD_N;
            S_RD_N: n_state = S_EXEC;
            S_EXEC: begin
                if (i_sts.opcode == OP_DIV) begin
                    n_state = i_sts.n_zero ? S_RESP : S_DIV;
                end else begin
                    n_state = S_WB;
                end
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_DIV_FIN;
                end
            end
            S_DIV_FIN: n_state = S_WB;
            S_WB:      n_state = S_RESP;
            S_RESP: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.status = ST_OK;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            S_DECODE: begin
                o_cmd.set_status = 1'b1;
                case (i_sts.opcode)
                    OP_PUSH: begin
                        o_cmd.status = i_sts.full ? ST_FULL : ST_OK;
                        o_cmd.push   = !i_sts.full;
                    end
                    OP_POP: begin
                        o_cmd.status = i_sts.empty ? ST_EMPTY : ST_OK;
                    end
                    default: begin
                        // unused opcodes fall through as a no-op with status ok
                        if (is_arith) begin
                            o_cmd.status = i_sts.few ? ST_FEW : ST_OK;
                        end
                    end
                endcase
            end
            S_RD_T: begin
                o_cmd.latch_t = 1'b1;
                if (i_sts.opcode == OP_POP) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_RD_N: o_cmd.latch_n = 1'b1;
            S_EXEC: begin
                if (i_sts.opcode == OP_DIV) begin
                    if (i_sts.n_zero) begin
                        o_cmd.set_status = 1'b1;
                        o_cmd.status     = ST_DIVZERO;
                    end else begin
                        o_cmd.div_start = 1'b1;
                    end
                end else begin
                    o_cmd.alu = 1'b1;
                end
            end
            S_DIV:     o_cmd.div_step = 1'b1;
            S_DIV_FIN: o_cmd.div_fin  = 1'b1;
            S_WB:      o_cmd.wb       = 1'b1;
            S_RESP:    o_cmd.load_out = i_sts.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> hw/rtl/rpn_dp.sv
`default_nettype none
module rpn_dp
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [OP_W-1:0]   i_opcode,
    input  wire logic [DATA_W-1:0] i_push_value,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_sts                o_sts,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic [ST_W-1:0]        o_out_status,
    output logic [DATA_W-1:0]      o_out_result,
    output logic [DEPTH_W-1:0]     o_out_depth
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [OP_W-1:0]      r_op;
    logic [DATA_W-1:0]    r_val;
    logic [CW-1:0]        r_count;
    logic [DATA_W-1:0]    r_t;
    logic [DATA_W-1:0]    r_n;
    logic [DATA_W-1:0]    r_res;
    logic [ST_W-1:0]      r_status;

    logic [DATA_W-1:0]    r_quo;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_dvs;
    logic                 r_neg;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic                 r_out_valid;
    logic [ST_W-1:0]      r_out_status;
    logic [DATA_W-1:0]    r_out_result;
    logic [DEPTH_W-1:0]   r_out_depth;

    logic [CW-1:0]         cnt_m1;
    logic [CW-1:0]         cnt_m2;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_W-1:0]     mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_W-1:0]     mem_rdata;
    logic [DATA_W-1:0]     alu_res;
    logic [DATA_W-1:0]     t_mag;
    logic [DATA_W-1:0]     n_mag;
    logic [DATA_W:0]       rem_sh;
    logic [DATA_W:0]       rem_diff;
    logic [CW+DEPTH_W-1:0] cnt_ext;
    logic                  out_free;

    assign cnt_m1 = r_count - CW'(1);
    assign cnt_m2 = r_count - CW'(2);

    assign mem_we    = i_cmd.push || i_cmd.wb;
    assign mem_waddr = i_cmd.push ? r_count[AW-1:0] : cnt_m2[AW-1:0];
    assign mem_wdata = i_cmd.push ? r_val : r_res;
    assign mem_raddr = i_cmd.rd_next ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        case (r_op)
            OP_ADD:  alu_res = r_t + r_n;
            OP_SUB:  alu_res = r_t - r_n;
            OP_MUL:  alu_res = r_t * r_n;
            default: alu_res = '0;
        endcase
    end

    assign t_mag = r_t[DATA_W-1] ? (DATA_W'(0) - r_t) : r_t;
    assign n_mag = r_n[DATA_W-1] ? (DATA_W'(0) - r_n) : r_n;

    // restoring division, one quotient bit per step
    assign rem_sh   = {r_rem, r_quo[DATA_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};

    assign cnt_ext  = {{DEPTH_W{1'b0}}, r_count};
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop || i_cmd.wb) begin
                r_count <= cnt_m1;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op  <= i_opcode;
            r_val <= i_push_value;
        end
        if (i_cmd.latch_t) begin
            r_t <= mem_rdata;
        end
        if (i_cmd.latch_n) begin
            r_n <= mem_rdata;
        end
        if (i_cmd.set_status) begin
            r_status <= i_cmd.status;
            r_res    <= '0;
        end else if (i_cmd.pop) begin
            r_res <= mem_rdata;
        end else if (i_cmd.alu) begin
            r_res <= alu_res;
        end else if (i_cmd.div_fin) begin
            r_res <= r_neg ? (DATA_W'(0) - r_quo) : r_quo;
        end
        if (i_cmd.div_start) begin
            r_quo     <= t_mag;
            r_rem     <= '0;
            r_dvs     <= n_mag;
            r_neg     <= r_t[DATA_W-1] ^ r_n[DATA_W-1];
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (!rem_diff[DATA_W]) begin
                r_rem <= rem_diff[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DATA_W-2:0], 1'b0};
            end
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_result <= r_res;
            r_out_depth  <= cnt_ext[DEPTH_W-1:0];
        end
    end

    always_comb begin
        o_sts          = '0;
        o_sts.opcode   = r_op;
        o_sts.full     = (r_count == CW'(STACK_DEPTH));
        o_sts.empty    = (r_count == '0);
        o_sts.few      = (r_count < CW'(2));
        o_sts.n_zero   = (r_n == '0);
        o_sts.div_last = (r_div_cnt == DIV_CNT_W'(DATA_W - 1));
        o_sts.out_free = out_free;
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_result = r_out_result;
    assign o_out_depth  = r_out_depth;

endmodule
`default_nettype wire

>>> hw/rtl/rpn_stack_calculator.sv
`default_nettype none
// 32-bit integer stack calculator. Each input item is one command (push, pop,
// add, subtract, multiply, divide) and yields exactly one result item with a
// status, the popped or computed value and the stack depth afterward. Items
// are handled one at a time, and the result item becomes valid in the same
// cycle as the next command can be taken. Arithmetic commands read their two
// operands one after another through the single read port of the stack
// memory, and divide uses a restoring divider that resolves one quotient bit
// per cycle. A push on a full stack, a pop on an empty one, an arithmetic
// command with too few operands and an unused opcode go from decode straight
// to the response; a divide by zero ends once both operands are read.
// The result sits in an output register, so a new command is taken while the
// previous result still waits; a command that finishes while that register is
// still occupied holds until it is taken.
// Errors (full, empty, too few operands, divide by zero) leave the stack as it was.
module rpn_stack_calculator
    import rpn_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // push_value[31:0]
    input  wire logic [2:0]  s_axis_tuser,   // opcode[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // result_value[31:0], depth_after[39:32]
    output logic [2:0]       m_axis_tuser    // status[2:0]
);

    t_dp_cmd             cmd;
    t_dp_sts             sts;
    logic [ST_W-1:0]     out_status;
    logic [DATA_W-1:0]   out_result;
    logic [DEPTH_W-1:0]  out_depth;

    rpn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rpn_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_opcode     (s_axis_tuser),
        .i_push_value (s_axis_tdata),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (out_status),
        .o_out_result (out_result),
        .o_out_depth  (out_depth)
    );

    assign m_axis_tdata = {out_depth, out_result};
    assign m_axis_tuser = out_status;

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
module testbench;
    import rpn_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int TARGET_ITEMS = 1800;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [DATA_W-1:0]  value;
        logic [DEPTH_W-1:0] depth;
    } t_reply;

    // software copy of the stack; computes the reply each command should give
    class stack_mirror;
        logic [DATA_W-1:0] entries [STACK_DEPTH_DEF];
        int unsigned depth;
        t_reply due_replies[$];
        int errors;

        function new();
            depth = 0;
            errors = 0;
        endfunction

        function logic [DATA_W-1:0] quot_toward_zero(logic [DATA_W-1:0] t,
                                                     logic [DATA_W-1:0] n);
            logic [DATA_W-1:0] t_mag;
            logic [DATA_W-1:0] n_mag;
            logic [DATA_W-1:0] q;
            t_mag = t[DATA_W-1] ? -t : t;
            n_mag = n[DATA_W-1] ? -n : n;
            q = t_mag / n_mag;
            return (t[DATA_W-1] ^ n[DATA_W-1]) ? -q : q;
        endfunction

        function void apply_command(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
            t_reply r;
            logic [DATA_W-1:0] top;
            logic [DATA_W-1:0] nxt;
            logic [DATA_W-1:0] res;
            r.status = ST_OK;
            r.value  = '0;
            case (op)
                OP_PUSH: begin
                    if (depth >= STACK_DEPTH_DEF) begin
                        r.status = ST_FULL;
                    end else begin
                        entries[depth] = val;
                        depth++;
                    end
                end
                OP_POP: begin
                    if (depth == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        depth--;
                        r.value = entries[depth];
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    if (depth < 2) begin
                        r.status = ST_FEW;
                    end else begin
                        top = entries[depth-1];
                        nxt = entries[depth-2];
                        if (op == OP_DIV && nxt == '0) begin
                            r.status = ST_DIVZERO;
                        end else begin
                            case (op)
                                OP_ADD:  res = top + nxt;
                                OP_SUB:  res = top - nxt;
                                OP_MUL:  res = top * nxt;
                                default: res = quot_toward_zero(top, nxt);
                            endcase
                            depth--;
                            entries[depth-1] = res;
                            r.value = res;
                        end
                    end
                end
                default: ;
            endcase
            r.depth = depth[DEPTH_W-1:0];
            due_replies.push_back(r);
        endfunction

        function void compare_field(string what, logic [DATA_W-1:0] want,
                                    logic [DATA_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
                errors++;
            end
        endfunction

        function void check_reply(logic [ST_W-1:0] st, logic [DATA_W-1:0] val,
                                  logic [DEPTH_W-1:0] dep);
            t_reply want;
            if (due_replies.size() == 0) begin
                $display("%0t: unexpected item, expected none, got status %0d value %h depth %0d",
                         $time, st, val, dep);
                errors++;
                return;
            end
            want = due_replies.pop_front();
            compare_field("status", DATA_W'(want.status), DATA_W'(st));
            compare_field("result_value", want.value, val);
            compare_field("depth_after", DATA_W'(want.depth), DATA_W'(dep));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [DATA_W-1:0]   s_axis_tdata = '0;   // push_value[31:0]
    logic [OP_W-1:0]     s_axis_tuser = '0;   // opcode[2:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [39:0]         m_axis_tdata;        // result_value[31:0], depth_after[39:32]
    logic [ST_W-1:0]     m_axis_tuser;        // status[2:0]

    stack_mirror mirror = new();
    int unsigned cycle_count = 0;
    int items_sent = 0;
    int tx_run = 0;
    bit tx_fast = 1'b0;

    rpn_stack_calculator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            mirror.check_reply(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[39:32]);
        end
    end

    // result side: random stalls, fast stretches, and two long hold-offs
    initial begin
        int hold;
        int stall;
        int run;
        int r;
        bit fast;
        hold = 0;
        stall = 0;
        run = 0;
        fast = 1'b0;
        forever begin
            @(posedge i_clk);
            if (cycle_count == 2000 || cycle_count == 20000) hold = 600;
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                if (run == 0) begin
                    fast = ($urandom_range(0, 3) == 0);
                    run = $urandom_range(20, 200);
                end
                run--;
                if (fast) begin
                    m_axis_tready <= 1'b1;
                end else if (stall > 0) begin
                    stall--;
                    m_axis_tready <= 1'b0;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 3) begin
                        stall = $urandom_range(10, 40);
                        m_axis_tready <= 1'b0;
                    end else begin
                        m_axis_tready <= (r >= 30);
                    end
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_run == 0) begin
            tx_fast = ($urandom_range(0, 3) == 0);
            tx_run = $urandom_range(10, 80);
        end
        tx_run--;
        if (tx_fast) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5, 6:    return DATA_W'($urandom_range(0, 31)) - 32'd16;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_arith();
        case ($urandom_range(0, 3))
            0:       return OP_ADD;
            1:       return OP_SUB;
            2:       return OP_MUL;
            default: return OP_DIV;
        endcase
    endfunction

    // valid stays high from one item to the next when there is no gap
    task automatic send_command(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= val;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        mirror.apply_command(op, val);
        items_sent++;
    endtask

    task automatic fill_and_drain();
        int k;
        while (mirror.depth < STACK_DEPTH_DEF) send_command(OP_PUSH, pick_value());
        for (k = 0; k < 3; k++) send_command(OP_PUSH, $urandom());
        for (k = 0; k < 4; k++) send_command(pick_arith(), $urandom());
        while (mirror.depth > 0) begin
            if ($urandom_range(0, 3) == 0) send_command(pick_arith(), $urandom());
            else send_command(OP_POP, $urandom());
        end
        send_command(OP_POP, $urandom());
        send_command(OP_ADD, $urandom());
    endtask

    initial begin
        int push_bias;
        int r;
        int next_burst;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty and single-entry errors, wraparound, min over minus one,
        // divide by zero, negative truncation, spare opcodes
        send_command(OP_POP,  32'h0000_0000);
        send_command(OP_ADD,  32'hFFFF_FFFF);
        send_command(OP_PUSH, 32'hFFFF_FFFF);
        send_command(OP_DIV,  32'h0000_0000);
        send_command(OP_PUSH, 32'h8000_0000);
        send_command(OP_DIV,  32'h5555_5555);
        send_command(OP_PUSH, 32'h0000_0000);
        send_command(OP_PUSH, 32'h0000_0005);
        send_command(OP_DIV,  32'hAAAA_AAAA);
        send_command(OP_SUB,  32'h0000_0000);
        send_command(OP_MUL,  32'h0000_0000);
        send_command(OP_PUSH, 32'h7FFF_FFFF);
        send_command(OP_ADD,  32'h0000_0000);
        send_command(OP_PUSH, 32'h0000_0002);
        send_command(OP_PUSH, 32'hFFFF_FFF9);
        send_command(OP_DIV,  32'h0000_0000);
        send_command(OP_SPARE_6, 32'hFFFF_FFFF);
        send_command(OP_SPARE_7, $urandom());
        send_command(OP_SUB,  32'h0000_0000);
        send_command(OP_POP,  32'h0000_0000);
        send_command(OP_POP,  32'hFFFF_FFFF);
        send_command(OP_POP,  32'h0000_0000);

        push_bias = 48;
        next_burst = items_sent + 300;
        while (items_sent < TARGET_ITEMS) begin
            // a fill and drain runs to roughly 270 items, so skip it near the end
            if (items_sent >= next_burst && items_sent + 300 <= TARGET_ITEMS) begin
                fill_and_drain();
                next_burst = items_sent + 450;
            end
            if ($urandom_range(0, 149) == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_bias = 30;
                    1:       push_bias = 48;
                    default: push_bias = 65;
                endcase
            end
            r = $urandom_range(0, 99);
            if (r < push_bias) send_command(OP_PUSH, pick_value());
            else if (r < push_bias + 12) send_command(OP_POP, $urandom());
            else if (r < 95) send_command(pick_arith(), $urandom());
            else if (r < 97) send_command(OP_SPARE_6, $urandom());
            else send_command(OP_SPARE_7, $urandom());
        end
        s_axis_tvalid <= 1'b0;

        while (mirror.due_replies.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mirror.errors == 0 && mirror.due_replies.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_ram.sv
hw/rtl/rpn_ctrl.sv
hw/rtl/rpn_dp.sv
hw/rtl/rpn_stack_calculator.sv
tb/sv/testbench.sv
